// File: hw/rtl/ber_integer_encoder_assert.svh
// Assertion macros used by the checker file.
`ifndef BER_INTEGER_ENCODER_ASSERT_SVH
`define BER_INTEGER_ENCODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BIE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BIE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bie_pkg.sv
`timescale 1ns / 1ps

package bie_pkg;

    // Encoding modes carried on the action field.
    typedef enum logic [1:0] {
        ACT_S32  = 2'd0,
        ACT_U32  = 2'd1,
        ACT_U64  = 2'd2,
        ACT_RSVD = 2'd3
    } action_t;

    // Output positions before the content bytes.
    localparam logic [3:0] POS_TAG = 4'd0;
    localparam logic [3:0] POS_LEN = 4'd1;

    // Fixed bytes of the encoding.
    localparam logic [7:0] PAD_BYTE = 8'h00;
    localparam logic [4:0] HDR_BYTES = 5'd2;

    // Depth of the queue between classifier and serializer.
    localparam int QDEPTH = 2;

    // One classified request, as handed to the serializer.
    typedef struct packed {
        logic        err;
        logic [7:0]  tag;
        logic [3:0]  len;
        logic [63:0] data;
        logic [15:0] space;
    } desc_t;

endpackage

// File: hw/rtl/bie_queue.sv
`timescale 1ns / 1ps

module bie_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bie_pkg::desc_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output bie_pkg::desc_t  q_data
);

    localparam int PTR_W = (bie_pkg::QDEPTH > 1) ? $clog2(bie_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(bie_pkg::QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(bie_pkg::QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(bie_pkg::QDEPTH);

    bie_pkg::desc_t   entry_reg [bie_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Advance pointers with wrap and track the fill level.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/bie_front.sv
`timescale 1ns / 1ps

module bie_front (
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_action,
    input  logic [7:0]      s_tag,
    input  logic [63:0]     s_value,
    input  logic [15:0]     s_space_left,
    input  logic            q_full,
    output logic            q_push,
    output bie_pkg::desc_t  q_data
);

    logic [31:0] v32;
    logic [63:0] data;
    logic [7:0]  data_bytes [8];
    logic        fits8, fits16, fits24;
    logic [3:0]  sig_bytes;
    logic [2:0]  top_idx;
    logic [3:0]  len;
    logic [4:0]  need;
    logic        err;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign v32     = s_value[31:0];

    // Signed fits: upper bits all repeat the sign bit of the kept part.
    assign fits8  = (&v32[31:7])  || !(|v32[31:7]);
    assign fits16 = (&v32[31:15]) || !(|v32[31:15]);
    assign fits24 = (&v32[31:23]) || !(|v32[31:23]);

    // Pick the source word and split it into bytes.
    always_comb begin
        data = s_value;
        if (bie_pkg::action_t'(s_action) == bie_pkg::ACT_S32 ||
            bie_pkg::action_t'(s_action) == bie_pkg::ACT_U32) begin
            data = {32'd0, v32};
        end
        for (int i = 0; i < 8; i++) begin
            data_bytes[i] = data[8*i +: 8];
        end
    end

    // Count significant unsigned bytes, at least one.
    always_comb begin
        sig_bytes = 4'd8;
        for (int k = 7; k >= 1; k--) begin
            if ((data >> (8 * k)) == 64'd0) begin
                sig_bytes = 4'(k);
            end
        end
        top_idx = 3'(sig_bytes - 4'd1);
    end

    // Content length per mode; unsigned gets a pad byte when the top bit is set.
    always_comb begin
        unique case (bie_pkg::action_t'(s_action))
            bie_pkg::ACT_S32: begin
                len = fits8 ? 4'd1 : fits16 ? 4'd2 : fits24 ? 4'd3 : 4'd4;
            end
            bie_pkg::ACT_U32, bie_pkg::ACT_U64, bie_pkg::ACT_RSVD: begin
                len = sig_bytes + {3'd0, data_bytes[top_idx][7]};
            end
            default: begin
                len = 4'd1;
            end
        endcase
    end

    // Check buffer space against tag, length and content.
    assign need = bie_pkg::HDR_BYTES + {1'b0, len};
    assign err  = (s_space_left < {11'd0, need});

    assign q_data.err   = err;
    assign q_data.tag   = s_tag;
    assign q_data.len   = len;
    assign q_data.data  = data;
    assign q_data.space = err ? s_space_left : (s_space_left - {11'd0, need});

endmodule

// File: hw/rtl/bie_back.sv
`timescale 1ns / 1ps

module bie_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  bie_pkg::desc_t  q_data,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last,
    output logic            m_error,
    output logic [15:0]     m_space_after
);

    logic           active_reg, active_next;
    bie_pkg::desc_t desc_reg, desc_next;
    logic [3:0]     pos_reg, pos_next;
    logic           m_valid_reg, m_valid_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic           error_reg, error_next;
    logic [15:0]    space_reg, space_next;

    logic           adv;
    logic [3:0]     bsel;
    logic [7:0]     cur_byte;
    logic           fin;

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last        = last_reg;
    assign m_error       = error_reg;
    assign m_space_after = space_reg;

    // Output stage moves when empty or taken.
    assign adv = !m_valid_reg || m_ready;

    // Content byte index counts down from the most significant byte.
    assign bsel = 4'(desc_reg.len + 4'd1 - pos_reg);
    assign fin  = desc_reg.err || (pos_reg == 4'(desc_reg.len + 4'd1));

    // Select the byte for the current position.
    always_comb begin
        if (desc_reg.err) begin
            cur_byte = bie_pkg::PAD_BYTE;
        end else if (pos_reg == bie_pkg::POS_TAG) begin
            cur_byte = desc_reg.tag;
        end else if (pos_reg == bie_pkg::POS_LEN) begin
            cur_byte = {4'd0, desc_reg.len};
        end else if (bsel[3]) begin
            cur_byte = bie_pkg::PAD_BYTE;
        end else begin
            cur_byte = desc_reg.data[{bsel[2:0], 3'b000} +: 8];
        end
    end

    // Emit one byte per advance; load the next request on the final byte.
    always_comb begin
        active_next  = active_reg;
        desc_next    = desc_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        error_next   = error_reg;
        space_next   = space_reg;
        q_pop        = 1'b0;
        if (adv) begin
            m_valid_next = active_reg;
            if (active_reg) begin
                byte_next  = cur_byte;
                last_next  = fin;
                error_next = desc_reg.err;
                space_next = fin ? desc_reg.space : 16'd0;
            end
            if (!active_reg || fin) begin
                q_pop       = q_valid;
                active_next = q_valid;
                desc_next   = q_data;
                pos_next    = bie_pkg::POS_TAG;
            end else begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold payload; no reset needed.
    always_ff @(posedge aclk) begin
        desc_reg  <= desc_next;
        pos_reg   <= pos_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        error_reg <= error_next;
        space_reg <= space_next;
    end

endmodule

// File: hw/rtl/ber_integer_encoder.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_        in   s_valid / s_ready    s_action, s_tag, s_value, s_space_left
// m_        out  m_valid / m_ready    m_out_byte, m_last, m_error, m_space_after
//
// A request yields 2 + n bytes (n = 1..9 content bytes), one per cycle while m_ready is
// high; a request short of space yields a single error byte. The classifier takes one
// request a cycle into a two-entry queue while the queue is not full, and the first
// byte passes the queue, the serializer's request register and the output register.
// Reset clears the queue and the output stage; there is no clearing pass.
// A stall on m_ready holds the output byte; s_ready drops only when the queue is full.
module ber_integer_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_tag,
    input  logic [63:0] s_value,
    input  logic [15:0] s_space_left,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic        m_error,
    output logic [15:0] m_space_after
);

    bie_pkg::desc_t push_data;
    bie_pkg::desc_t q_data;
    logic           q_full, q_push, q_pop, q_valid;

    bie_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_tag        (s_tag),
        .s_value      (s_value),
        .s_space_left (s_space_left),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (push_data)
    );

    bie_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    bie_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .m_error       (m_error),
        .m_space_after (m_space_after)
    );

endmodule

// File: hw/rtl/bie_checker.sv
`timescale 1ns / 1ps
`include "ber_integer_encoder_assert.svh"

module bie_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_last,
    input logic        m_error,
    input logic [15:0] m_space_after
);

    // A stalled byte holds.
    `BIE_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last), "output changed while stalled")

    // A space error is always a single, final result.
    `BIE_ASSERT(a_err_last, aclk, aresetn, m_valid && m_error |-> m_last && (m_out_byte == 8'h00), "error result not final or carries a byte")

    // Remaining space shows only on the final byte.
    `BIE_ASSERT(a_space_zero, aclk, aresetn, m_valid && !m_last |-> (m_space_after == 16'd0) && !m_error, "space or error before final byte")

    // Nothing is offered while in reset.
    `BIE_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "output valid right after reset")

endmodule

bind ber_integer_encoder bie_checker u_bie_checker (.*);

// File: test/ber_integer_encoder_tb.sv
`timescale 1ns / 1ps

module ber_integer_encoder_tb;

    // One output byte as the block presents it
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        err;
        logic [15:0] space;
    } ber_byte_t;

    // One directed request; want_len of zero leaves the bytes to encode_integer
    typedef struct packed {
        bie_pkg::action_t act;
        logic [7:0]       tag;
        logic [63:0]      val;
        logic [15:0]      space;
        logic [3:0]       want_len;
        logic             want_err;
        logic [15:0]      want_space;
        logic [87:0]      want_bytes;
    } dir_row_t;

    localparam int DIR_ROWS     = 23;
    localparam int RAND_ITEMS   = 400;
    localparam int QUIET_TAIL   = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int CYCLE_LIMIT  = 600000;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // signed extremes and sign trimming
        '{bie_pkg::ACT_S32, 8'h02, 64'h0, 16'd100, 4'd3, 1'b0, 16'd97, {24'h020100, 64'd0}},
        '{bie_pkg::ACT_S32, 8'h02, 64'h7FFF_FFFF, 16'd6, 4'd6, 1'b0, 16'd0,
          {48'h0204_7FFF_FFFF, 40'd0}},
        '{bie_pkg::ACT_S32, 8'h02, 64'h8000_0000, 16'd10, 4'd6, 1'b0, 16'd4,
          {48'h0204_8000_0000, 40'd0}},
        '{bie_pkg::ACT_S32, 8'h02, 64'hFFFF_FFFF, 16'd3, 4'd3, 1'b0, 16'd0,
          {24'h0201FF, 64'd0}},
        '{bie_pkg::ACT_S32, 8'h02, 64'h7F, 16'd50, 4'd0, 1'b0, 16'd0, 88'd0},
        '{bie_pkg::ACT_S32, 8'h02, 64'h80, 16'd50, 4'd0, 1'b0, 16'd0, 88'd0},
        '{bie_pkg::ACT_S32, 8'h02, 64'hFFFF_FF80, 16'd50, 4'd0, 1'b0, 16'd0, 88'd0},
        '{bie_pkg::ACT_S32, 8'h02, 64'hFFFF_FF7F, 16'd50, 4'd0, 1'b0, 16'd0, 88'd0},
        // upper half ignored in a 32-bit mode
        '{bie_pkg::ACT_S32, 8'hA5, 64'hFFFF_FFFF_0000_0080, 16'd50, 4'd0, 1'b0, 16'd0,
          88'd0},
        // unsigned 32-bit with and without the pad byte
        '{bie_pkg::ACT_U32, 8'h42, 64'hFFFF_FFFF, 16'hFFFF, 4'd7, 1'b0, 16'd65528,
          {56'h4205_00FF_FFFF_FF, 32'd0}},
        '{bie_pkg::ACT_U32, 8'h42, 64'h0, 16'd3, 4'd3, 1'b0, 16'd0, {24'h420100, 64'd0}},
        '{bie_pkg::ACT_U32, 8'h42, 64'hDEAD_BEEF_0000_0001, 16'd20, 4'd0, 1'b0, 16'd0,
          88'd0},
        '{bie_pkg::ACT_U32, 8'h42, 64'h8000, 16'd20, 4'd0, 1'b0, 16'd0, 88'd0},
        // unsigned 64-bit, longest encoding
        '{bie_pkg::ACT_U64, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd11, 4'd11, 1'b0, 16'd0,
          88'hFF09_00FF_FFFF_FFFF_FFFF_FF},
        '{bie_pkg::ACT_U64, 8'h00, 64'h8000_0000_0000_0000, 16'd40, 4'd0, 1'b0, 16'd0,
          88'd0},
        '{bie_pkg::ACT_U64, 8'h00, 64'h7FFF_FFFF_FFFF_FFFF, 16'd40, 4'd0, 1'b0, 16'd0,
          88'd0},
        '{bie_pkg::ACT_U64, 8'h00, 64'h1_0000_0000, 16'd40, 4'd0, 1'b0, 16'd0, 88'd0},
        // unused mode behaves as unsigned 64-bit
        '{bie_pkg::ACT_RSVD, 8'h30, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd0, 1'b0, 16'd0,
          88'd0},
        '{bie_pkg::ACT_RSVD, 8'h30, 64'h1, 16'd3, 4'd0, 1'b0, 16'd0, 88'd0},
        // short of space
        '{bie_pkg::ACT_S32, 8'h02, 64'h0, 16'd2, 4'd1, 1'b1, 16'd2, 88'd0},
        '{bie_pkg::ACT_S32, 8'h02, 64'h0, 16'd0, 4'd1, 1'b1, 16'd0, 88'd0},
        '{bie_pkg::ACT_U64, 8'h02, 64'hFFFF_FFFF_FFFF_FFFF, 16'd10, 4'd1, 1'b1, 16'd10,
          88'd0},
        '{bie_pkg::ACT_U32, 8'h02, 64'hFFFF_FFFF, 16'd6, 4'd1, 1'b1, 16'd6, 88'd0}
    };

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action      = 2'd0;
    logic [7:0]  s_tag         = 8'd0;
    logic [63:0] s_value       = 64'd0;
    logic [15:0] s_space_left  = 16'd0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;
    logic        m_error;
    logic [15:0] m_space_after;

    ber_byte_t pending_bytes [$];
    ber_byte_t got_byte;
    ber_byte_t want_byte;

    int idle_pct      = 0;
    int stall_left    = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int bytes_checked = 0;
    int requests_sent = 0;
    int short_count   = 0;
    int mode_count [4];

    ber_integer_encoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_tag         (s_tag),
        .s_value       (s_value),
        .s_space_left  (s_space_left),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .m_error       (m_error),
        .m_space_after (m_space_after)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Build the BER bytes of one request and queue them; return how many
    function automatic int encode_integer(input bie_pkg::action_t act,
                                          input logic [7:0] tag,
                                          input logic [63:0] val,
                                          input logic [15:0] space);
        logic [63:0] v;
        logic [7:0]  raw [8];
        logic [7:0]  body [9];
        int          width;
        int          first;
        int          n;
        int          need;
        ber_byte_t   r;
        width = (act == bie_pkg::ACT_S32 || act == bie_pkg::ACT_U32) ? 4 : 8;
        v = (width == 4) ? {32'd0, val[31:0]} : val;
        for (int i = 0; i < width; i++)
            raw[i] = v[8 * (width - 1 - i) +: 8];
        first = 0;
        n = 0;
        if (act == bie_pkg::ACT_S32) begin
            // drop a leading byte that only repeats the sign of the next one
            while (first < width - 1 &&
                   ((raw[first] == 8'h00 && !raw[first + 1][7]) ||
                    (raw[first] == 8'hFF && raw[first + 1][7])))
                first++;
        end else begin
            // drop leading zeros, then pad if the top bit would read as a sign
            while (first < width - 1 && raw[first] == 8'h00)
                first++;
            if (raw[first][7]) begin
                body[n] = bie_pkg::PAD_BYTE;
                n++;
            end
        end
        for (int i = first; i < width; i++) begin
            body[n] = raw[i];
            n++;
        end
        need = bie_pkg::HDR_BYTES + n;
        if (space < need) begin
            r = '{8'h00, 1'b1, 1'b1, space};
            pending_bytes.push_back(r);
            return 1;
        end
        r = '{tag, 1'b0, 1'b0, 16'd0};
        pending_bytes.push_back(r);
        r = '{n[7:0], 1'b0, 1'b0, 16'd0};
        pending_bytes.push_back(r);
        for (int i = 0; i < n; i++) begin
            r.data  = body[i];
            r.last  = (i == n - 1);
            r.err   = 1'b0;
            r.space = (i == n - 1) ? space - need[15:0] : 16'd0;
            pending_bytes.push_back(r);
        end
        return n + 2;
    endfunction

    // Queue the bytes typed into a directed row
    function automatic void push_typed(input dir_row_t row);
        ber_byte_t r;
        if (row.want_err) begin
            r = '{8'h00, 1'b1, 1'b1, row.want_space};
            pending_bytes.push_back(r);
        end else begin
            for (int i = 0; i < row.want_len; i++) begin
                r.data  = row.want_bytes[87 - 8 * i -: 8];
                r.last  = (i == row.want_len - 1);
                r.err   = 1'b0;
                r.space = r.last ? row.want_space : 16'd0;
                pending_bytes.push_back(r);
            end
        end
    endfunction

    // Random integer with a random number of significant bits
    function automatic logic [63:0] pick_value(input bie_pkg::action_t act);
        logic [63:0] v;
        int          w;
        int          keep;
        w = (act == bie_pkg::ACT_S32 || act == bie_pkg::ACT_U32) ? 32 : 64;
        v = {$urandom, $urandom};
        keep = $urandom_range(0, w);
        if (keep < 64)
            v = v & ((64'd1 << keep) - 64'd1);
        // negative-looking patterns
        if ($urandom_range(0, 3) == 0)
            v = (w == 32) ? {32'd0, ~v[31:0]} : ~v;
        // junk in the ignored half
        if (w == 32 && $urandom_range(0, 1) == 1)
            v[63:32] = $urandom;
        return v;
    endfunction

    function automatic logic [15:0] pick_space();
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom_range(0, 12));
            2: return 16'hFFFF - 16'($urandom_range(0, 3));
            3: return 16'($urandom);
            default: return 16'($urandom_range(11, 300));
        endcase
    endfunction

    // Offer one request, with an optional idle burst first, and wait for accept
    task automatic offer_request(input bie_pkg::action_t act, input logic [7:0] tag,
                                 input logic [63:0] val, input logic [15:0] space);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_tag        <= tag;
        s_value      <= val;
        s_space_left <= space;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        mode_count[act]++;
    endtask

    // Hold off new requests until every expected byte is out
    task automatic drain_pending();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_bytes.size() != 0);
    endtask

    // Stall the result side in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted byte with the oldest expectation; bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, pending_bytes.size());
            $display("TB_ERROR");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            got_byte = '{m_out_byte, m_last, m_error, m_space_after};
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected byte %02h last %0b err %0b space %0d at cycle %0d",
                             got_byte.data, got_byte.last, got_byte.err, got_byte.space,
                             cycle_count);
            end else begin
                want_byte = pending_bytes.pop_front();
                if (got_byte !== want_byte) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch at cycle %0d: want %02h/%0b/%0b/%0d, ",
                                  "got %02h/%0b/%0b/%0d (byte/last/err/space)"},
                                 cycle_count, want_byte.data, want_byte.last,
                                 want_byte.err, want_byte.space, got_byte.data,
                                 got_byte.last, got_byte.err, got_byte.space);
                end
            end
        end
    end

    // Stimulus: reset, directed table, random requests, drain, verdict
    initial begin
        bie_pkg::action_t act;
        logic [63:0]      val;
        logic [15:0]      space;
        int               count;
        foreach (mode_count[i])
            mode_count[i] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            offer_request(DIR_TABLE[r].act, DIR_TABLE[r].tag, DIR_TABLE[r].val,
                          DIR_TABLE[r].space);
            if (DIR_TABLE[r].want_len != 0) begin
                push_typed(DIR_TABLE[r]);
                if (DIR_TABLE[r].want_err)
                    short_count++;
            end else begin
                count = encode_integer(DIR_TABLE[r].act, DIR_TABLE[r].tag,
                                       DIR_TABLE[r].val, DIR_TABLE[r].space);
                if (count == 1)
                    short_count++;
            end
        end
        drain_pending();

        // random requests, idling rate changes every 40
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            end
            if (k >= RAND_ITEMS - QUIET_TAIL)
                idle_pct = 0;
            if (k == RAND_ITEMS / 2)
                drain_pending();
            case ($urandom_range(0, 9))
                0, 1, 2: act = bie_pkg::ACT_S32;
                3, 4, 5: act = bie_pkg::ACT_U32;
                6, 7, 8: act = bie_pkg::ACT_U64;
                default: act = bie_pkg::ACT_RSVD;
            endcase
            val   = pick_value(act);
            space = pick_space();
            offer_request(act, 8'($urandom), val, space);
            count = encode_integer(act, s_tag, val, space);
            if (count == 1)
                short_count++;
        end

        // drain and settle
        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Encoded %0d integers (%0d short of space) into %0d checked bytes",
                 requests_sent, short_count, bytes_checked);
        $display("Per mode: s32 %0d, u32 %0d, u64 %0d, unused %0d; %0d failures",
                 mode_count[bie_pkg::ACT_S32], mode_count[bie_pkg::ACT_U32],
                 mode_count[bie_pkg::ACT_U64], mode_count[bie_pkg::ACT_RSVD],
                 fail_count + pending_bytes.size());
        if (fail_count == 0 && pending_bytes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
